// ----- rtl/pct_pkg.sv -----
// shared types and codes for the pausable countdown timer
// no dependencies; imported by every rtl module of the timer
package pct_pkg;

   // timer modes as they appear on the result channel
   localparam logic [2:0] MODE_TICKING  = 3'd0;
   localparam logic [2:0] MODE_PAUSED   = 3'd1;
   localparam logic [2:0] MODE_RINGING  = 3'd2;
   localparam logic [2:0] MODE_IDLE     = 3'd3;
   localparam logic [2:0] MODE_SCRAPPED = 3'd4;

   // request op codes
   localparam logic [2:0] OP_EVALUATE = 3'd0;
   localparam logic [2:0] OP_PAUSE    = 3'd1;
   localparam logic [2:0] OP_RESUME   = 3'd2;
   localparam logic [2:0] OP_RESET    = 3'd3;
   localparam logic [2:0] OP_RESTART  = 3'd4;
   localparam logic [2:0] OP_DISMISS  = 3'd5;
   localparam logic [2:0] OP_DISPOSE  = 3'd6;

   // internal command codes after classification
   localparam int CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_EVALUATE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PAUSE    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RESUME   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RESET    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESTART  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DISMISS  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_DISPOSE  = 3'd6;
   localparam logic [CMD_W-1:0] CMD_NOP      = 3'd7;

   // register indexes on the csr port
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_PERIOD = 2'd0;
   localparam logic [1:0] REG_SCRAP  = 2'd1;
   localparam logic [1:0] REG_QUIET  = 2'd2;

   // configuration seen by the execution side
   typedef struct packed {
      logic [31:0] period_ticks;
      logic        auto_scrap;
      logic        auto_quiet;
   } cfg_type;

endpackage

// ----- rtl/pct_regs.sv -----
// csr register file of the timer: period and the two auto flags
// depends on pct_pkg
module pct_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pct_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output pct_pkg::cfg_type               cfg
);
   import pct_pkg::*;

   logic [31:0] period_ff, period_in;
   logic        scrap_ff, scrap_in;
   logic        quiet_ff, quiet_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // write decode
   always_comb begin
      period_in = period_ff;
      scrap_in  = scrap_ff;
      quiet_in  = quiet_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PERIOD: period_in = csr_pwdata;
            REG_SCRAP:  scrap_in  = csr_pwdata[0];
            REG_QUIET:  quiet_in  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         scrap_ff  <= 1'b0;
         quiet_ff  <= 1'b0;
      end else begin
         period_ff <= period_in;
         scrap_ff  <= scrap_in;
         quiet_ff  <= quiet_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_PERIOD: csr_prdata = period_ff;
         REG_SCRAP:  csr_prdata = {31'd0, scrap_ff};
         REG_QUIET:  csr_prdata = {31'd0, quiet_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.period_ticks = period_ff;
   assign cfg.auto_scrap   = scrap_ff;
   assign cfg.auto_quiet   = quiet_ff;

endmodule

// ----- rtl/pct_front.sv -----
// request front end: accepts requests and classifies the op into a command
// depends on pct_pkg; feeds pct_queue
module pct_front #(
   parameter int TIME_BITS = 32
) (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_op,
   input  logic [31:0]                   req_now,
   input  logic                          queue_full,
   output logic                          push,
   output logic [pct_pkg::CMD_W-1:0]     push_cmd,
   output logic [TIME_BITS-1:0]          push_now
);
   import pct_pkg::*;

   // hold off while the queue has no room
   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

   // time is carried at the internal width
   assign push_now = TIME_BITS'(req_now);

   // op classification, the spare code becomes a no-op
   always_comb begin
      case (req_op)
         OP_EVALUATE: push_cmd = CMD_EVALUATE;
         OP_PAUSE:    push_cmd = CMD_PAUSE;
         OP_RESUME:   push_cmd = CMD_RESUME;
         OP_RESET:    push_cmd = CMD_RESET;
         OP_RESTART:  push_cmd = CMD_RESTART;
         OP_DISMISS:  push_cmd = CMD_DISMISS;
         OP_DISPOSE:  push_cmd = CMD_DISPOSE;
         default:     push_cmd = CMD_NOP;
      endcase
   end

endmodule

// ----- rtl/pct_queue.sv -----
// small fifo between the front end and the execution side
// depends on pct_pkg only for the import convention
module pct_queue #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);
   import pct_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/pct_back.sv -----
// execution side: timer state update, then status and elapsed-time stages
// depends on pct_pkg; takes commands from pct_queue
module pct_back #(
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pct_pkg::cfg_type          cfg,
   input  logic                      head_valid,
   input  logic [pct_pkg::CMD_W-1:0] head_cmd,
   input  logic [TIME_BITS-1:0]      head_now,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_timer_mode,
   output logic [31:0]               rsp_time_left,
   output logic [31:0]               rsp_time_spent,
   output logic [31:0]               rsp_expiry_time
);
   import pct_pkg::*;

   // timer state
   logic [2:0]           mode_ff, mode_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] span_ff, span_in;
   logic [TIME_BITS-1:0] end_ff, end_in;

   // stage a: state snapshot after the command
   logic                 sa_valid_ff;
   logic [2:0]           sa_mode_ff;
   logic [TIME_BITS-1:0] sa_start_ff, sa_span_ff, sa_end_ff, sa_now_ff;

   // stage b: remaining time and deadline
   logic                 sb_valid_ff, sb_valid_in;
   logic [2:0]           sb_mode_ff;
   logic [TIME_BITS-1:0] sb_left_ff, sb_left_in;
   logic [TIME_BITS-1:0] sb_expiry_ff, sb_expiry_in;

   // output register
   logic                 out_valid_ff;
   logic [2:0]           out_mode_ff;
   logic [TIME_BITS-1:0] out_left_ff, out_expiry_ff, out_spent_ff, out_spent_in;

   logic                 adv;
   logic [TIME_BITS-1:0] period;
   logic [TIME_BITS-1:0] elapsed;
   logic [TIME_BITS-1:0] sa_elapsed;
   logic [2:0]           dismiss_mode;

   // whole back end moves unless a result is waiting on a stall
   assign adv    = ~(out_valid_ff & rsp_stall);
   assign pop    = adv & head_valid;
   assign period = TIME_BITS'(cfg.period_ticks);

   assign elapsed      = head_now - start_ff;
   assign dismiss_mode = cfg.auto_scrap ? MODE_SCRAPPED : MODE_IDLE;

   // command execution
   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      span_in  = span_ff;
      end_in   = end_ff;
      case (head_cmd)
         CMD_EVALUATE: begin
            if (mode_ff == MODE_TICKING && elapsed >= span_ff) begin
               end_in  = head_now;
               mode_in = cfg.auto_quiet ? dismiss_mode : MODE_RINGING;
            end
         end
         CMD_PAUSE: begin
            if (mode_ff == MODE_TICKING) begin
               span_in = (span_ff > elapsed) ? span_ff - elapsed : '0;
               mode_in = MODE_PAUSED;
            end else if (mode_ff == MODE_RINGING) begin
               mode_in = dismiss_mode;
            end
         end
         CMD_RESUME: begin
            if (mode_ff == MODE_PAUSED) begin
               start_in = head_now;
               mode_in  = MODE_TICKING;
            end
         end
         CMD_RESET: begin
            if (mode_ff == MODE_TICKING) begin
               start_in = head_now;
            end else begin
               mode_in = MODE_PAUSED;
            end
            span_in = period;
         end
         CMD_RESTART: begin
            span_in  = period;
            start_in = head_now;
            mode_in  = MODE_TICKING;
         end
         CMD_DISMISS: begin
            if (mode_ff inside {MODE_TICKING, MODE_PAUSED, MODE_RINGING}) begin
               mode_in = dismiss_mode;
            end
         end
         CMD_DISPOSE: mode_in = MODE_SCRAPPED;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         span_ff  <= '0;
         end_ff   <= '0;
      end else if (pop) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         span_ff  <= span_in;
         end_ff   <= end_in;
      end
   end

   // stage a capture
   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (adv) begin
         sa_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         sa_mode_ff  <= mode_in;
         sa_start_ff <= start_in;
         sa_span_ff  <= span_in;
         sa_end_ff   <= end_in;
         sa_now_ff   <= head_now;
      end
   end

   // remaining time and deadline from the snapshot
   assign sa_elapsed  = sa_now_ff - sa_start_ff;
   assign sb_valid_in = sa_valid_ff;

   always_comb begin
      case (sa_mode_ff)
         MODE_TICKING: begin
            sb_left_in   = (sa_span_ff > sa_elapsed) ? sa_span_ff - sa_elapsed : '0;
            sb_expiry_in = sa_start_ff + sa_span_ff;
         end
         MODE_PAUSED: begin
            sb_left_in   = sa_span_ff;
            sb_expiry_in = '0;
         end
         default: begin
            sb_left_in   = '0;
            sb_expiry_in = sa_end_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else if (adv) begin
         sb_valid_ff <= sb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_mode_ff   <= sa_mode_ff;
         sb_left_ff   <= sb_left_in;
         sb_expiry_ff <= sb_expiry_in;
      end
   end

   // elapsed part of the period, saturated
   assign out_spent_in = (period > sb_left_ff) ? period - sb_left_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= sb_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_mode_ff   <= sb_mode_ff;
         out_left_ff   <= sb_left_ff;
         out_expiry_ff <= sb_expiry_ff;
         out_spent_ff  <= out_spent_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_timer_mode  = out_mode_ff;
   assign rsp_time_left   = 32'(out_left_ff);
   assign rsp_time_spent  = 32'(out_spent_ff);
   assign rsp_expiry_time = 32'(out_expiry_ff);

endmodule

// ----- rtl/pausable_countdown_timer.sv -----
// pausable countdown timer, top level: csr block, front end, queue, back end
// depends on pct_pkg, pct_regs, pct_front, pct_queue, pct_back
//
//   channel  handshake              payload
//   req      req_valid / req_stall  req_op, req_now
//   rsp      rsp_valid / rsp_stall  rsp_timer_mode, rsp_time_left,
//                                   rsp_time_spent, rsp_expiry_time
//   csr      apb write, pready = 1  csr_paddr, csr_pwdata, csr_prdata
//
// one request per cycle sustained while no result waits on rsp_stall; the state
// update loops through the state registers in the back end. a taken request passes
// through the queue, state update, remaining time and elapsed time stages in order.
// reset is synchronous and returns the timer to idle with all marks zero.
// rsp_stall on a waiting result freezes the back end; the two-entry queue then fills
// and raises req_stall.
module pausable_countdown_timer #(
   parameter int TIME_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_op,
   input  logic [31:0]                    req_now,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_timer_mode,
   output logic [31:0]                    rsp_time_left,
   output logic [31:0]                    rsp_time_spent,
   output logic [31:0]                    rsp_expiry_time,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pct_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import pct_pkg::*;

   localparam int ENTRY_W = CMD_W + TIME_BITS;

   cfg_type              cfg;
   logic                 push, pop, q_empty, q_full;
   logic [CMD_W-1:0]     push_cmd, head_cmd;
   logic [TIME_BITS-1:0] push_now, head_now;
   logic [ENTRY_W-1:0]   head_entry;

   pct_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pct_front #(.TIME_BITS(TIME_BITS)) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_op     (req_op),
      .req_now    (req_now),
      .queue_full (q_full),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_now   (push_now)
   );

   pct_queue #(.WIDTH(ENTRY_W), .DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_now}),
      .pop       (pop),
      .pop_data  (head_entry),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign head_cmd = head_entry[ENTRY_W-1:TIME_BITS];
   assign head_now = head_entry[TIME_BITS-1:0];

   pct_back #(.TIME_BITS(TIME_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .head_valid      (~q_empty),
      .head_cmd        (head_cmd),
      .head_now        (head_now),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_timer_mode  (rsp_timer_mode),
      .rsp_time_left   (rsp_time_left),
      .rsp_time_spent  (rsp_time_spent),
      .rsp_expiry_time (rsp_expiry_time)
   );

endmodule

// ----- rtl/pct_checker.sv -----
// port-level checks for the pausable countdown timer, bound to the top level
// depends on pct_pkg and pausable_countdown_timer
module pct_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_timer_mode,
   input logic [31:0] rsp_time_left,
   input logic [31:0] rsp_time_spent,
   input logic [31:0] rsp_expiry_time
);
   import pct_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_timer_mode)
         && $stable(rsp_time_left) && $stable(rsp_time_spent)
         && $stable(rsp_expiry_time))
      else $error("stalled result changed");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a paused timer reports no deadline
   a_paused_expiry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timer_mode == MODE_PAUSED |-> rsp_expiry_time == 32'd0)
      else $error("paused timer shows a deadline");

   // a ringing, idle or scrapped timer has nothing left
   a_stopped_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_timer_mode == MODE_RINGING || rsp_timer_mode == MODE_IDLE
         || rsp_timer_mode == MODE_SCRAPPED) |-> rsp_time_left == 32'd0)
      else $error("stopped timer shows remaining time");

endmodule

bind pausable_countdown_timer pct_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_timer_mode  (rsp_timer_mode),
   .rsp_time_left   (rsp_time_left),
   .rsp_time_spent  (rsp_time_spent),
   .rsp_expiry_time (rsp_expiry_time)
);

// ----- verif/pct_tb_pkg.sv -----
// scoreboard for the pausable countdown timer testbench: predicts the status of each request
// and checks the status results in order. depends on pct_pkg for mode, op and register codes
`timescale 1ns / 100ps

package pct_tb_pkg;
   import pct_pkg::*;

   // op code outside the defined set, must leave the timer unchanged
   localparam logic [2:0] OP_UNKNOWN = 3'd7;
   // mismatch lines printed before going quiet
   localparam int MAX_SHOWN = 40;

   typedef struct packed {
      logic [2:0]  timer_mode;
      logic [31:0] time_left;
      logic [31:0] time_spent;
      logic [31:0] expiry_time;
   } timer_status_type;

   class timer_scoreboard;
      // register copies
      logic [31:0] period_ticks;
      logic        auto_scrap;
      logic        auto_quiet;
      // timer state copies
      logic [2:0]  mode;
      logic [31:0] start_mark;
      logic [31:0] span_left;
      logic [31:0] end_mark;
      // status results still owed by the block, oldest first
      timer_status_type due_status[$];
      int errors;

      function new();
         period_ticks = '0;
         auto_scrap   = 1'b0;
         auto_quiet   = 1'b0;
         mode         = MODE_IDLE;
         start_mark   = '0;
         span_left    = '0;
         end_mark     = '0;
         errors       = 0;
      endfunction

      function int pending();
         return due_status.size();
      endfunction

      function void set_reg(input logic [1:0] idx, input logic [31:0] value);
         case (idx)
            REG_PERIOD: period_ticks = value;
            REG_SCRAP:  auto_scrap   = value[0];
            REG_QUIET:  auto_quiet   = value[0];
            default: ;
         endcase
      endfunction

      function logic [31:0] floor_sub(input logic [31:0] a, input logic [31:0] b);
         return (a > b) ? a - b : 32'd0;
      endfunction

      function logic [2:0] dismissed_mode();
         return auto_scrap ? MODE_SCRAPPED : MODE_IDLE;
      endfunction

      // advance the timer by one accepted request and queue the status it yields
      function void apply_command(input logic [2:0] op, input logic [31:0] now);
         logic [31:0]      elapsed;
         timer_status_type status;
         elapsed = now - start_mark;
         case (op)
            OP_EVALUATE: begin
               if (mode == MODE_TICKING && elapsed >= span_left) begin
                  end_mark = now;
                  mode = auto_quiet ? dismissed_mode() : MODE_RINGING;
               end
            end
            OP_PAUSE: begin
               if (mode == MODE_TICKING) begin
                  span_left = floor_sub(span_left, elapsed);
                  mode = MODE_PAUSED;
               end else if (mode == MODE_RINGING) begin
                  mode = dismissed_mode();
               end
            end
            OP_RESUME: begin
               if (mode == MODE_PAUSED) begin
                  start_mark = now;
                  mode = MODE_TICKING;
               end
            end
            OP_RESET: begin
               if (mode == MODE_TICKING) begin
                  start_mark = now;
               end else if (mode != MODE_PAUSED) begin
                  mode = MODE_PAUSED;
               end
               span_left = period_ticks;
            end
            OP_RESTART: begin
               span_left  = period_ticks;
               start_mark = now;
               mode       = MODE_TICKING;
            end
            OP_DISMISS: begin
               if (mode == MODE_TICKING || mode == MODE_PAUSED || mode == MODE_RINGING)
                  mode = dismissed_mode();
            end
            OP_DISPOSE: mode = MODE_SCRAPPED;
            default: ;
         endcase

         // status after the command
         status.timer_mode = mode;
         if (mode == MODE_TICKING) begin
            status.time_left   = floor_sub(span_left, now - start_mark);
            status.expiry_time = start_mark + span_left;
         end else if (mode == MODE_PAUSED) begin
            status.time_left   = span_left;
            status.expiry_time = '0;
         end else begin
            status.time_left   = '0;
            status.expiry_time = end_mark;
         end
         status.time_spent = floor_sub(period_ticks, status.time_left);
         due_status.push_back(status);
      endfunction

      task report(input string what);
         if (errors < MAX_SHOWN)
            $display("mismatch: %s", what);
         errors++;
      endtask

      task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
         if (got !== want)
            report($sformatf("%s got 0x%h expected 0x%h", name, got, want));
      endtask

      // match one accepted result against the oldest owed status
      task check_status(input timer_status_type got);
         timer_status_type want;
         if (due_status.size() == 0) begin
            report($sformatf("result with nothing pending, mode %0d left 0x%h",
                             got.timer_mode, got.time_left));
         end else begin
            want = due_status.pop_front();
            compare_field("timer_mode", 32'(got.timer_mode), 32'(want.timer_mode));
            compare_field("time_left", got.time_left, want.time_left);
            compare_field("time_spent", got.time_spent, want.time_spent);
            compare_field("expiry_time", got.expiry_time, want.expiry_time);
         end
      endtask
   endclass

endpackage

// ----- verif/pausable_countdown_timer_tb.sv -----
// testbench top for the pausable countdown timer: directed commands, then random command
// sequences under several idling patterns. depends on pct_pkg, pct_tb_pkg and the timer rtl
`timescale 1ns / 100ps

module pausable_countdown_timer_tb;
   import pct_pkg::*;
   import pct_tb_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam int SEGMENTS      = 8;
   localparam int SEGMENT_ITEMS = 88;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_op;
   logic [31:0] req_now;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_timer_mode;
   logic [31:0] rsp_time_left;
   logic [31:0] rsp_time_spent;
   logic [31:0] rsp_expiry_time;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   timer_scoreboard board;
   int          send_idle_pct;
   int          rsp_stall_pct;
   int          seg_items;
   int          idle_cycles;
   logic [31:0] tick_cursor;
   logic [31:0] step_max;

   pausable_countdown_timer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_now         (req_now),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_timer_mode  (rsp_timer_mode),
      .rsp_time_left   (rsp_time_left),
      .rsp_time_spent  (rsp_time_spent),
      .rsp_expiry_time (rsp_expiry_time),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stall, check every accepted result
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         board.check_status({rsp_timer_mode, rsp_time_left, rsp_time_spent, rsp_expiry_time});
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
          || (csr_psel && csr_penable && csr_pready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // one request, with random idle cycles ahead of it
   task automatic send_request(input logic [2:0] op, input logic [31:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_op    <= op;
      req_now   <= now;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.apply_command(op, now);
      seg_items++;
   endtask

   // stop requests and wait until every owed result has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle, then access until pready
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      board.set_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // either a stray request or a restart followed by a short run of commands
   task automatic run_sequence();
      int n;
      int r;
      logic [2:0] op;
      if ($urandom_range(99) < 15) begin
         send_request(3'($urandom_range(7)), $urandom);
      end else begin
         tick_cursor = tick_cursor + $urandom_range(100);
         send_request(OP_RESTART, tick_cursor);
         n = $urandom_range(8, 1);
         repeat (n) begin
            r = $urandom_range(99);
            if (r < 55)      op = OP_EVALUATE;
            else if (r < 65) op = OP_PAUSE;
            else if (r < 75) op = OP_RESUME;
            else if (r < 82) op = OP_RESET;
            else if (r < 88) op = OP_DISMISS;
            else if (r < 92) op = OP_DISPOSE;
            else if (r < 96) op = OP_RESTART;
            else             op = OP_UNKNOWN;
            tick_cursor = tick_cursor + $urandom_range(step_max);
            send_request(op, tick_cursor);
         end
      end
   endtask

   initial begin
      int seg;
      int pick;
      logic [31:0] period;
      board         = new();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      seg_items     = 0;
      idle_cycles   = 0;
      tick_cursor   = '0;
      step_max      = 32'd8;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_EVALUATE;
      req_now       = '0;
      rsp_stall     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: commands on an idle timer, expiry, pause while ringing, overdue pause
      csr_write(REG_PERIOD, 32'd10);
      csr_write(REG_SCRAP, 32'd0);
      csr_write(REG_QUIET, 32'd0);
      send_request(OP_EVALUATE, 32'd0);
      send_request(OP_DISMISS, 32'd0);
      send_request(OP_UNKNOWN, 32'hFFFF_FFFF);
      send_request(OP_RESTART, 32'd100);
      send_request(OP_EVALUATE, 32'd109);
      send_request(OP_EVALUATE, 32'd110);
      send_request(OP_PAUSE, 32'd111);
      send_request(OP_RESET, 32'd120);
      send_request(OP_RESUME, 32'd200);
      send_request(OP_PAUSE, 32'd230);
      send_request(OP_RESUME, 32'd240);
      send_request(OP_EVALUATE, 32'd240);
      send_request(OP_RESET, 32'd250);
      // time wrapping past zero, then running backwards
      send_request(OP_RESTART, 32'hFFFF_FFFF);
      send_request(OP_RESET, 32'd5);
      send_request(OP_EVALUATE, 32'd4);
      send_request(OP_DISMISS, 32'd6);
      send_request(OP_DISPOSE, 32'd7);

      // full-length period with quiet expiry into scrapped
      drain();
      csr_write(REG_PERIOD, 32'hFFFF_FFFF);
      csr_write(REG_SCRAP, 32'd1);
      csr_write(REG_QUIET, 32'd1);
      send_request(OP_RESTART, 32'd0);
      send_request(OP_EVALUATE, 32'hFFFF_FFFE);
      send_request(OP_EVALUATE, 32'hFFFF_FFFF);

      // period shrunk while the timer runs: elapsed time saturates at zero
      drain();
      csr_write(REG_PERIOD, 32'd20);
      csr_write(REG_QUIET, 32'd0);
      send_request(OP_RESTART, 32'd1000);
      drain();
      csr_write(REG_PERIOD, 32'd0);
      send_request(OP_EVALUATE, 32'd1005);
      send_request(OP_DISMISS, 32'd1006);

      // random command sequences, one register setting and idling pattern per segment
      for (seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         case (seg % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin send_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         pick = $urandom_range(9);
         if (pick == 0)      period = 32'd0;
         else if (pick == 1) period = 32'hFFFF_FFFF;
         else if (pick == 2) period = $urandom;
         else                period = $urandom_range(40, 1);
         step_max    = (period <= 32'd40) ? period / 2 + 2 : 32'd16;
         tick_cursor = $urandom;
         csr_write(REG_PERIOD, period);
         csr_write(REG_SCRAP, 32'($urandom_range(1)));
         csr_write(REG_QUIET, 32'($urandom_range(1)));
         seg_items = 0;
         while (seg_items < SEGMENT_ITEMS) run_sequence();
      end

      drain();
      if (board.pending() != 0)
         board.report($sformatf("%0d results never arrived", board.pending()));
      if (board.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/pct_pkg.sv
rtl/pct_regs.sv
rtl/pct_front.sv
rtl/pct_queue.sv
rtl/pct_back.sv
rtl/pausable_countdown_timer.sv
rtl/pct_checker.sv
verif/pct_tb_pkg.sv
verif/pausable_countdown_timer_tb.sv
